>>> rtl/chs_pkg.sv
// Shared types and constants for the chained hash set.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package chs_pkg;

  // Fixed widths of the request and result fields on the ports.
  localparam int KEY_FIELD_W    = 16;
  localparam int BUCKET_FIELD_W = 5;

  // Default geometry of the table.
  localparam int DEF_NUM_BUCKETS  = 19;
  localparam int DEF_BUCKET_DEPTH = 8;
  localparam int DEF_KEY_WIDTH    = 16;

  typedef enum logic {
    FUNC_INSERT = 1'b0,
    FUNC_SEARCH = 1'b1
  } func_t;

  typedef enum logic {
    STATUS_OK   = 1'b0,
    STATUS_FULL = 1'b1
  } status_t;

  // Outcome of one request, passed from the table to the output register.
  typedef struct packed {
    status_t status;
    logic    found;
  } result_t;

endpackage

>>> rtl/chained_hash_set.sv
// Top level of the chained hash set: stream ports and the result register.
// Depends on chs_pkg, chs_bucket_calc and chs_table.
`timescale 1ns / 1ps

// The block keeps a set of keys in NUM_BUCKETS buckets of BUCKET_DEPTH slots.
// Each request on the slave stream is an insert (s_tuser low) or a search
// (s_tuser high) of the key in s_tdata. A key lands in bucket key modulo
// NUM_BUCKETS; an insert appends it to the next free slot of that bucket,
// duplicates allowed, and a search compares all filled slots at once.
// Every request produces exactly one result on the master stream: found,
// a status that flags an insert dropped on a full bucket, and the bucket.
// From the accepting edge, a request passes the reciprocal-multiply modulo
// stages, the table stage for the row read, compare and write-back, and the
// result register that drives m_tvalid. Throughput is one request per cycle
// while the receiver does not stall; a request that hits the bucket written
// just before it sees that write through a bypass, so no bubbles are needed.
// Reset clears all fill counts at once, so the table is empty and ready in
// the first cycle after reset; key slots are never compared before written.
// When the receiver stalls, the result register holds and each stage
// upstream keeps filling until the pipeline is full, then s_tready drops.
module chained_hash_set #(
  parameter int NUM_BUCKETS  = chs_pkg::DEF_NUM_BUCKETS,
  parameter int BUCKET_DEPTH = chs_pkg::DEF_BUCKET_DEPTH,
  parameter int KEY_WIDTH    = chs_pkg::DEF_KEY_WIDTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [chs_pkg::KEY_FIELD_W-1:0] s_tdata,   // [15:0] key
  input  logic       s_tuser,    // [0] func: 0 insert, 1 search
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata     // [0] found, [1] status, [6:2] bucket, [7] zero
);

  localparam int BucketW = $clog2(NUM_BUCKETS);

  // Between the modulo unit and the table.
  logic                 calc_valid, calc_ready;
  chs_pkg::func_t       calc_func;
  logic [KEY_WIDTH-1:0] calc_key;
  logic [BucketW-1:0]   calc_bucket;

  // Between the table and the result register.
  logic                 tbl_valid, tbl_ready;
  chs_pkg::result_t     tbl_result;
  logic [BucketW-1:0]   tbl_bucket;

  // Result register.
  logic                 out_valid;
  chs_pkg::result_t     out_result;
  logic [chs_pkg::BUCKET_FIELD_W-1:0] out_bucket;

  chs_bucket_calc #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .KEY_WIDTH   (KEY_WIDTH)
  ) u_calc (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_func    (chs_pkg::func_t'(s_tuser)),
    .in_key     (KEY_WIDTH'(s_tdata)),
    .out_valid  (calc_valid),
    .out_ready  (calc_ready),
    .out_func   (calc_func),
    .out_key    (calc_key),
    .out_bucket (calc_bucket)
  );

  chs_table #(
    .NUM_BUCKETS  (NUM_BUCKETS),
    .BUCKET_DEPTH (BUCKET_DEPTH),
    .KEY_WIDTH    (KEY_WIDTH)
  ) u_table (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (calc_valid),
    .in_ready   (calc_ready),
    .in_func    (calc_func),
    .in_key     (calc_key),
    .in_bucket  (calc_bucket),
    .out_valid  (tbl_valid),
    .out_ready  (tbl_ready),
    .out_result (tbl_result),
    .out_bucket (tbl_bucket)
  );

  // The result register takes a new result whenever it is empty or being read.
  assign tbl_ready = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (tbl_ready) begin
      out_valid <= tbl_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_ready) begin
      out_result <= tbl_result;
      out_bucket <= chs_pkg::BUCKET_FIELD_W'(tbl_bucket);
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_bucket, out_result.status, out_result.found};

endmodule

>>> rtl/chs_bucket_calc.sv
// Two-stage bucket index unit: key modulo the bucket count by reciprocal multiply.
// Depends on chs_pkg.
`timescale 1ns / 1ps

module chs_bucket_calc #(
  parameter int NUM_BUCKETS = chs_pkg::DEF_NUM_BUCKETS,
  parameter int KEY_WIDTH   = chs_pkg::DEF_KEY_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  chs_pkg::func_t                 in_func,
  input  logic [KEY_WIDTH-1:0]           in_key,
  output logic                           out_valid,
  input  logic                           out_ready,
  output chs_pkg::func_t                 out_func,
  output logic [KEY_WIDTH-1:0]           out_key,
  output logic [$clog2(NUM_BUCKETS)-1:0] out_bucket
);

  localparam int BucketW = $clog2(NUM_BUCKETS);
  localparam int Shift   = KEY_WIDTH + BucketW;
  localparam int RecipW  = KEY_WIDTH + 1;
  localparam int ProdW   = KEY_WIDTH + RecipW;
  localparam int QnW     = KEY_WIDTH + BucketW;
  localparam logic [63:0] RecipFull = (64'd1 << Shift) / NUM_BUCKETS;
  localparam logic [RecipW-1:0] Recip = RecipFull[RecipW-1:0];

  logic                 v1, v2;
  chs_pkg::func_t       f1, f2;
  logic [KEY_WIDTH-1:0] k1, k2, q2, q_est;
  logic                 en1, en2;
  logic [ProdW-1:0]     prod;
  logic [QnW-1:0]       qn;
  logic [BucketW:0]     rem_raw, rem_fix;

  assign en2      = !v2 || out_ready;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  // Floor reciprocal underestimates the quotient by at most one.
  assign prod  = ProdW'(k1) * ProdW'(Recip);
  assign q_est = KEY_WIDTH'(prod >> Shift);

  assign qn      = QnW'(q2) * QnW'(NUM_BUCKETS);
  assign rem_raw = (BucketW + 1)'(k2 - KEY_WIDTH'(qn));
  assign rem_fix = (rem_raw >= (BucketW + 1)'(NUM_BUCKETS)) ?
                   rem_raw - (BucketW + 1)'(NUM_BUCKETS) : rem_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      f1 <= in_func;
      k1 <= in_key;
    end
    if (en2) begin
      f2 <= f1;
      k2 <= k1;
      q2 <= q_est;
    end
  end

  assign out_valid  = v2;
  assign out_func   = f2;
  assign out_key    = k2;
  assign out_bucket = BucketW'(rem_fix);

endmodule

>>> rtl/chs_table.sv
// Bucket row memory, fill counts and the parallel slot compare.
// Depends on chs_pkg.
`timescale 1ns / 1ps

module chs_table #(
  parameter int NUM_BUCKETS  = chs_pkg::DEF_NUM_BUCKETS,
  parameter int BUCKET_DEPTH = chs_pkg::DEF_BUCKET_DEPTH,
  parameter int KEY_WIDTH    = chs_pkg::DEF_KEY_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  chs_pkg::func_t                 in_func,
  input  logic [KEY_WIDTH-1:0]           in_key,
  input  logic [$clog2(NUM_BUCKETS)-1:0] in_bucket,
  output logic                           out_valid,
  input  logic                           out_ready,
  output chs_pkg::result_t               out_result,
  output logic [$clog2(NUM_BUCKETS)-1:0] out_bucket
);

  localparam int BucketW = $clog2(NUM_BUCKETS);
  localparam int CountW  = $clog2(BUCKET_DEPTH + 1);
  localparam int SlotW   = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;

  typedef logic [BUCKET_DEPTH-1:0][KEY_WIDTH-1:0] row_t;

  row_t                 rows [NUM_BUCKETS];
  row_t                 rd_row, merged;
  logic [CountW-1:0]    fill_counts [NUM_BUCKETS];
  logic                 vb;
  chs_pkg::func_t       fb;
  logic [KEY_WIDTH-1:0] kb;
  logic [BucketW-1:0]   bb;
  logic                 fwd_hit;
  logic [SlotW-1:0]     fwd_slot;
  logic [KEY_WIDTH-1:0] fwd_key;
  logic [CountW-1:0]    n;
  logic [SlotW-1:0]     slot;
  logic                 full, en_b, wr_en, hit;

  assign en_b     = !vb || out_ready;
  assign in_ready = en_b;

  assign n     = fill_counts[bb];
  assign slot  = n[SlotW-1:0];
  assign full  = (n >= CountW'(BUCKET_DEPTH));
  assign wr_en = vb && out_ready && (fb == chs_pkg::FUNC_INSERT) && !full;

  // The row read was launched at the same edge as the previous request's
  // write, so that slot may be stale and is patched with the written key.
  always_comb begin
    merged = rd_row;
    if (fwd_hit) merged[fwd_slot] = fwd_key;
  end

  always_comb begin
    hit = 1'b0;
    for (int i = 0; i < BUCKET_DEPTH; i++) begin
      if ((CountW'(i) < n) && (merged[i] == kb)) hit = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) rows[bb][slot] <= kb;
    if (en_b) rd_row <= rows[in_bucket];
  end

  always_ff @(posedge clk) begin
    if (en_b) begin
      fb       <= in_func;
      kb       <= in_key;
      bb       <= in_bucket;
      fwd_hit  <= wr_en && (bb == in_bucket);
      fwd_slot <= slot;
      fwd_key  <= kb;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
      for (int i = 0; i < NUM_BUCKETS; i++) fill_counts[i] <= '0;
    end else begin
      if (en_b) vb <= in_valid;
      if (wr_en) fill_counts[bb] <= n + CountW'(1);
    end
  end

  assign out_valid         = vb;
  assign out_result.found  = (fb == chs_pkg::FUNC_SEARCH) && hit;
  assign out_result.status = ((fb == chs_pkg::FUNC_INSERT) && full) ?
                             chs_pkg::STATUS_FULL : chs_pkg::STATUS_OK;
  assign out_bucket        = bb;

  a_found_only_search: assert property (@(posedge clk) disable iff (rst)
    (vb && out_result.found) |-> (fb == chs_pkg::FUNC_SEARCH))
    else $error("found set on an insert");

  a_full_only_insert: assert property (@(posedge clk) disable iff (rst)
    (vb && out_result.status == chs_pkg::STATUS_FULL) |-> (fb == chs_pkg::FUNC_INSERT))
    else $error("full status on a search");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    vb |-> (n <= CountW'(BUCKET_DEPTH)))
    else $error("fill count beyond bucket depth");

  a_count_advances: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> (fill_counts[$past(bb)] == $past(n) + CountW'(1)))
    else $error("fill count did not advance after insert");

endmodule
